### rtl/imm_pkg.sv
`timescale 1ns / 1ps

package imm_pkg;

  localparam int DEF_MAX_DIM = 8;
  localparam int IDX_FW      = 3;
  localparam int VAL_W       = 32;
  localparam int CFG_W       = 4;
  localparam int REG_IDX_W   = 2;

  localparam logic [REG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INNER_LEN = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  typedef enum logic [1:0] {
    FUNC_WRITE_A = 2'd0,
    FUNC_WRITE_B = 2'd1,
    FUNC_COMPUTE = 2'd2
  } func_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef struct packed {
    func_t                    func;
    logic [IDX_FW-1:0]        row;
    logic [IDX_FW-1:0]        col;
    logic signed [VAL_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic [IDX_FW-1:0]        out_row;
    logic [IDX_FW-1:0]        out_col;
    logic signed [VAL_W-1:0]  sum;
    logic                     last;
  } rsp_t;

  // Travels with each multiply-accumulate step through the pipeline.
  typedef struct packed {
    logic              first;
    logic              lastk;
    logic              zero;
    logic              lastel;
    logic [IDX_FW-1:0] i;
    logic [IDX_FW-1:0] j;
  } tag_t;

endpackage

### rtl/integer_matrix_multiply_unit.sv
`timescale 1ns / 1ps

// Integer matrix multiply. Elements of A and B are written one beat each (func 0 and 1,
// addressed by row and col; indexes at or above MAX_DIM are dropped). A compute beat
// (func 2) walks i, j, k over the clamped dimensions and emits C in row-major order,
// last set on the final element. Both operand memories have one read port, so the block
// does one multiply-accumulate per cycle while the output is not stalled: a compute beat
// holds the input until its last read is issued, and results pass through the memory
// read, multiply and accumulate registers. Output stall freezes the pipeline. rows_a or
// cols_b of zero makes the compute beat return nothing; an inner_len of zero gives sums
// of zero. Products and sums wrap to 32 bits.
module integer_matrix_multiply_unit
  import imm_pkg::*;
#(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req_data,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp_data,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
    return (d > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : d;
  endfunction

  logic [CFG_W-1:0] rows_a;
  logic [CFG_W-1:0] inner_len;
  logic [CFG_W-1:0] cols_b;
  logic [CFG_W-1:0] nr;
  logic [CFG_W-1:0] nk;
  logic [CFG_W-1:0] nc;
  logic [CFG_W-1:0] nk_eff;

  seq_state_t state;
  seq_state_t state_next;

  logic [IDX_W-1:0] ci;
  logic [IDX_W-1:0] cj;
  logic [IDX_W-1:0] ck;
  logic             i_end;
  logic             j_end;
  logic             k_end;

  logic accept;
  logic start;
  logic issue;
  logic done_issue;
  logic freeze;
  logic in_range;
  logic wr_a;
  logic wr_b;

  logic [AW-1:0] w_addr;
  logic [AW-1:0] a_addr;
  logic [AW-1:0] b_addr;

  logic [VAL_W-1:0] mem_a [DEPTH];
  logic [VAL_W-1:0] mem_b [DEPTH];
  logic [VAL_W-1:0] rd_a;
  logic [VAL_W-1:0] rd_b;

  tag_t             tag0;
  tag_t             t1;
  tag_t             t2;
  logic             v1;
  logic             v2;
  logic [VAL_W-1:0] prod;
  logic [VAL_W-1:0] acc;
  logic [VAL_W-1:0] acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= CFG_W'(8);
      inner_len <= CFG_W'(8);
      cols_b    <= CFG_W'(8);
    end else if (wr_en) begin
      case (wr_index)
        REG_ROWS_A:    rows_a    <= wr_data;
        REG_INNER_LEN: inner_len <= wr_data;
        REG_COLS_B:    cols_b    <= wr_data;
        default: ;
      endcase
    end
  end

  assign nr     = clamp_dim(rows_a);
  assign nk     = clamp_dim(inner_len);
  assign nc     = clamp_dim(cols_b);
  assign nk_eff = (nk == '0) ? CFG_W'(1) : nk;

  assign freeze   = rsp_valid && rsp_stall;
  assign accept   = req_valid && !req_stall;
  assign start    = accept && (req_data.func == FUNC_COMPUTE) && (nr != '0) && (nc != '0);
  assign in_range = (int'(req_data.row) < MAX_DIM) && (int'(req_data.col) < MAX_DIM);
  assign wr_a     = accept && (req_data.func == FUNC_WRITE_A) && in_range;
  assign wr_b     = accept && (req_data.func == FUNC_WRITE_B) && in_range;
  assign w_addr   = AW'(int'(req_data.row) * MAX_DIM + int'(req_data.col));

  assign i_end      = (ci == IDX_W'(nr - CFG_W'(1)));
  assign j_end      = (cj == IDX_W'(nc - CFG_W'(1)));
  assign k_end      = (ck == IDX_W'(nk_eff - CFG_W'(1)));
  assign done_issue = issue && i_end && j_end && k_end;

  // Sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      SEQ_IDLE: if (start) state_next = SEQ_RUN;
      SEQ_RUN:  if (done_issue) state_next = SEQ_IDLE;
      default:  state_next = SEQ_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    req_stall = 1'b0;
    issue     = 1'b0;
    case (state)
      SEQ_IDLE: ;
      SEQ_RUN: begin
        req_stall = 1'b1;
        issue     = !freeze;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ci <= '0;
      cj <= '0;
      ck <= '0;
    end else if (start) begin
      ci <= '0;
      cj <= '0;
      ck <= '0;
    end else if (issue) begin
      if (!k_end) begin
        ck <= ck + IDX_W'(1);
      end else begin
        ck <= '0;
        if (!j_end) begin
          cj <= cj + IDX_W'(1);
        end else begin
          cj <= '0;
          ci <= ci + IDX_W'(1);
        end
      end
    end
  end

  assign a_addr = AW'(int'(ci) * MAX_DIM + int'(ck));
  assign b_addr = AW'(int'(ck) * MAX_DIM + int'(cj));

  always_comb begin
    tag0.first  = (ck == '0);
    tag0.lastk  = k_end;
    tag0.zero   = (nk == '0);
    tag0.lastel = i_end && j_end && k_end;
    tag0.i      = IDX_FW'(ci);
    tag0.j      = IDX_FW'(cj);
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[w_addr] <= req_data.value;
    end
    if (wr_b) begin
      mem_b[w_addr] <= req_data.value;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_a <= mem_a[a_addr];
      rd_b <= mem_b[b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (!freeze) begin
      v1 <= issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (!freeze) begin
      t1   <= tag0;
      t2   <= t1;
      prod <= t1.zero ? '0 : VAL_W'(rd_a * rd_b);
    end
  end

  assign acc_next = (t2.first ? '0 : acc) + prod;

  always_ff @(posedge clk) begin
    if (v2 && !freeze) begin
      acc <= acc_next;
      if (t2.lastk) begin
        rsp_data.out_row <= t2.i;
        rsp_data.out_col <= t2.j;
        rsp_data.sum     <= acc_next;
        rsp_data.last    <= t2.lastel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (!freeze) begin
      rsp_valid <= v2 && t2.lastk;
    end
  end

`ifndef ASSERT_OFF
  a_no_issue_when_idle: assert property (@(posedge clk) disable iff (rst)
    (state == SEQ_IDLE && !freeze) |=> !v1)
    else $error("read stage valid without an issued read");

  a_last_is_corner: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.last) |->
      (rsp_data.out_row == IDX_FW'(nr - CFG_W'(1)) &&
       rsp_data.out_col == IDX_FW'(nc - CFG_W'(1))))
    else $error("last beat not at the final element");

  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_stall) |=> (!rsp_valid || $past(v2 && t2.lastk)))
    else $error("result beat repeated");

  a_start_from_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == SEQ_IDLE))
    else $error("compute accepted while sequencer busy");
`endif

endmodule

### tb/sv/integer_matrix_multiply_unit_tb.sv
`timescale 1ns / 1ps

module integer_matrix_multiply_unit_tb;
  import imm_pkg::*;

  localparam int MAX_DIM = DEF_MAX_DIM;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 400;
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  req_t                 req_data = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b1;
  rsp_t                 rsp_data;
  logic                 wr_en = 1'b0;
  logic [REG_IDX_W-1:0] wr_index = '0;
  logic [CFG_W-1:0]     wr_data = '0;

  // shadow of the block: operand stores, written flags, dimension registers
  logic [VAL_W-1:0] a_mem [MAX_DIM*MAX_DIM];
  logic [VAL_W-1:0] b_mem [MAX_DIM*MAX_DIM];
  bit               a_set [MAX_DIM*MAX_DIM];
  bit               b_set [MAX_DIM*MAX_DIM];
  logic [CFG_W-1:0] cfg_rows = 4'd8;
  logic [CFG_W-1:0] cfg_inner = 4'd8;
  logic [CFG_W-1:0] cfg_cols = 4'd8;
  rsp_t             expected_products [$];
  rsp_t             front_product;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit hold_go = 1'b0;

  integer_matrix_multiply_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data (rsp_data),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always #5 clk = ~clk;

  function automatic int clamp_dim(logic [CFG_W-1:0] d);
    return (d > MAX_DIM) ? MAX_DIM : int'(d);
  endfunction

  function automatic void predict_beat(req_t beat);
    int nr;
    int nk;
    int nc;
    int n;
    logic [VAL_W-1:0] acc;
    rsp_t res;
    case (beat.func)
      FUNC_WRITE_A: begin
        a_mem[{beat.row, beat.col}] = beat.value;
        a_set[{beat.row, beat.col}] = 1'b1;
      end
      FUNC_WRITE_B: begin
        b_mem[{beat.row, beat.col}] = beat.value;
        b_set[{beat.row, beat.col}] = 1'b1;
      end
      FUNC_COMPUTE: begin
        nr = clamp_dim(cfg_rows);
        nk = clamp_dim(cfg_inner);
        nc = clamp_dim(cfg_cols);
        n = 0;
        for (int i = 0; i < nr; i++) begin
          for (int j = 0; j < nc; j++) begin
            acc = '0;
            for (int k = 0; k < nk; k++)
              acc = acc + a_mem[i*MAX_DIM+k] * b_mem[k*MAX_DIM+j];
            res.out_row = IDX_FW'(i);
            res.out_col = IDX_FW'(j);
            res.sum = acc;
            res.last = (n + 1 == nr * nc);
            n++;
            expected_products.push_back(res);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic req_t make_beat(func_t f, int r, int c, logic [VAL_W-1:0] v);
    req_t beat;
    beat.func = f;
    beat.row = IDX_FW'(r);
    beat.col = IDX_FW'(c);
    beat.value = v;
    return beat;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return VAL_W'($urandom_range(0, 40)) - 32'd20;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    if ($urandom_range(0, 99) < 85) return CFG_W'($urandom_range(1, 3));
    return CFG_W'($urandom_range(0, 15));
  endfunction

  task automatic report_error(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // expectations are queued when a beat is first offered; the payload is held until taken
  task automatic send_beat(input req_t beat);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_data <= beat;
    predict_beat(beat);
    if (beat.func != func_t'(FUNC_SPARE)) items_sent++;
    do @(posedge clk); while (req_stall !== 1'b0);
  endtask

  task automatic idle_sender();
    @(negedge clk);
    req_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    case (idx)
      REG_ROWS_A: cfg_rows = val;
      REG_INNER_LEN: cfg_inner = val;
      REG_COLS_B: cfg_cols = val;
      default: ;
    endcase
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic set_dims(logic [CFG_W-1:0] r, logic [CFG_W-1:0] k, logic [CFG_W-1:0] c);
    idle_sender();
    wait_drained();
    write_reg(REG_ROWS_A, r);
    write_reg(REG_INNER_LEN, k);
    write_reg(REG_COLS_B, c);
  endtask

  // write every element the next product reads that has not been written yet
  task automatic fill_needed();
    int nr;
    int nk;
    int nc;
    nr = clamp_dim(cfg_rows);
    nk = clamp_dim(cfg_inner);
    nc = clamp_dim(cfg_cols);
    for (int i = 0; i < nr; i++)
      for (int k = 0; k < nk; k++)
        if (!a_set[i*MAX_DIM+k]) send_beat(make_beat(FUNC_WRITE_A, i, k, pick_value()));
    for (int k = 0; k < nk; k++)
      for (int j = 0; j < nc; j++)
        if (!b_set[k*MAX_DIM+j]) send_beat(make_beat(FUNC_WRITE_B, k, j, pick_value()));
  endtask

  task automatic send_compute();
    send_beat(make_beat(FUNC_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom));
  endtask

  task automatic test_directed_products();
    set_dims(4'd2, 4'd2, 4'd2);
    // products and sums overflow and wrap
    send_beat(make_beat(FUNC_WRITE_A, 0, 0, 32'h8000_0000));
    send_beat(make_beat(FUNC_WRITE_A, 0, 1, 32'h7fff_ffff));
    send_beat(make_beat(FUNC_WRITE_A, 1, 0, 32'hffff_ffff));
    send_beat(make_beat(FUNC_WRITE_A, 1, 1, 32'h0000_0000));
    send_beat(make_beat(FUNC_WRITE_B, 0, 0, 32'hffff_ffff));
    send_beat(make_beat(FUNC_WRITE_B, 0, 1, 32'h7fff_ffff));
    send_beat(make_beat(FUNC_WRITE_B, 1, 0, 32'h8000_0000));
    send_beat(make_beat(FUNC_WRITE_B, 1, 1, 32'h0000_0001));
    send_beat(make_beat(FUNC_WRITE_A, 7, 7, 32'h5555_5555));
    send_beat(make_beat(FUNC_WRITE_B, 7, 7, 32'haaaa_aaaa));
    // unused func code must be dropped
    send_beat(make_beat(func_t'(FUNC_SPARE), 7, 7, 32'hffff_ffff));
    send_compute();
    send_beat(make_beat(FUNC_WRITE_A, 0, 0, 32'h0000_0003));
    send_compute();
  endtask

  task automatic test_dimension_extremes();
    logic [CFG_W-1:0] dims [9][3];
    dims = '{'{4'd0, 4'd2, 4'd2}, '{4'd2, 4'd2, 4'd0}, '{4'd2, 4'd0, 4'd2},
             '{4'd0, 4'd0, 4'd0}, '{4'd1, 4'd1, 4'd1}, '{4'd15, 4'd1, 4'd1},
             '{4'd1, 4'd1, 4'd15}, '{4'd1, 4'd15, 4'd1}, '{4'd8, 4'd8, 4'd8}};
    for (int t = 0; t < 9; t++) begin
      set_dims(dims[t][0], dims[t][1], dims[t][2]);
      fill_needed();
      send_compute();
    end
    idle_sender();
    wait_drained();
    write_reg(REG_SPARE, 4'hf);
    write_reg(REG_SPARE, 4'h0);
    send_compute();
  endtask

  task automatic test_random_products(int phase_items);
    int stop_at;
    stop_at = items_sent + phase_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 2) == 0) begin
        idle_sender();
        wait_drained();
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE, CFG_W'($urandom));
          else write_reg(REG_IDX_W'($urandom_range(0, 2)), pick_dim());
        end
      end
      repeat ($urandom_range(0, 4)) begin
        if ($urandom_range(0, 7) == 0)
          send_beat(make_beat(func_t'(FUNC_SPARE), $urandom_range(0, 7),
                              $urandom_range(0, 7), $urandom));
        else
          send_beat(make_beat($urandom_range(0, 1) ? FUNC_WRITE_B : FUNC_WRITE_A,
                              $urandom_range(0, 7), $urandom_range(0, 7), pick_value()));
      end
      fill_needed();
      send_compute();
      if ($urandom_range(0, 3) == 0) send_compute();
    end
  endtask

  // receiver holds off while computes keep arriving, so the input must back up
  task automatic test_backpressure();
    int saved_pct;
    set_dims(4'd2, 4'd2, 4'd2);
    fill_needed();
    idle_sender();
    wait_drained();
    saved_pct = send_idle_pct;
    send_idle_pct = 0;
    hold_go = 1'b1;
    repeat (10) send_compute();
    send_idle_pct = saved_pct;
  endtask

  always @(negedge clk) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (expected_products.size() == 0) begin
        report_error($sformatf("unexpected result (%0d,%0d) sum %0d last %0b",
                               rsp_data.out_row, rsp_data.out_col, rsp_data.sum,
                               rsp_data.last));
      end else begin
        front_product = expected_products.pop_front();
        if (rsp_data.out_row !== front_product.out_row)
          report_error($sformatf("out_row got %0d want %0d", rsp_data.out_row,
                                 front_product.out_row));
        if (rsp_data.out_col !== front_product.out_col)
          report_error($sformatf("out_col got %0d want %0d", rsp_data.out_col,
                                 front_product.out_col));
        if (rsp_data.sum !== front_product.sum)
          report_error($sformatf("sum at (%0d,%0d) got %0d want %0d",
                                 front_product.out_row, front_product.out_col,
                                 rsp_data.sum, front_product.sum));
        if (rsp_data.last !== front_product.last)
          report_error($sformatf("last at (%0d,%0d) got %0b want %0b",
                                 front_product.out_row, front_product.out_col,
                                 rsp_data.last, front_product.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TIMEOUT: no beat moved for %0d cycles", QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 27;
    recv_idle_pct = 46;
    test_directed_products();
    test_dimension_extremes();
    test_random_products(76);

    send_idle_pct = 46;
    recv_idle_pct = 27;
    test_random_products(76);
    test_backpressure();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_products(77);

    idle_sender();
    wait_drained();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
rtl/imm_pkg.sv
rtl/integer_matrix_multiply_unit.sv
tb/sv/integer_matrix_multiply_unit_tb.sv
